// ----- rtl/rws_pkg.sv -----
package rws_pkg;

   // Request kinds.
   localparam logic [1:0] KIND_INITIAL = 2'd0;
   localparam logic [1:0] KIND_SEEK    = 2'd1;
   localparam logic [1:0] KIND_META    = 2'd2;

   // Byte limits.
   localparam logic [40:0] MIB              = 41'd1048576;
   localparam logic [40:0] META_MAX_BYTES   = 41'd16 * MIB;
   localparam logic [40:0] SMALL_FILE_LIMIT = 41'd64 * MIB;
   localparam logic [40:0] TAIL_MARGIN      = 41'd10 * MIB;
   localparam logic [31:0] RATE_FAST        = 32'd10485760;
   localparam logic [31:0] RATE_MID         = 32'd5242880;
   localparam logic [31:0] RATE_SLOW        = 32'd1048576;

   // Divider numerator and divisor widths.
   localparam int NumW = 30;
   localparam int DivW = 27;
   localparam int CmpW = DivW + 8;

   localparam logic [NumW-1:0] STARTUP_MIN_N = NumW'(24'd0) | (NumW'(1) << 24);
   localparam logic [NumW-1:0] STARTUP_MAX_N = NumW'(1) << 25;
   localparam logic [NumW-1:0] META_CAP_N    = NumW'(1) << 24;
   localparam logic [NumW-1:0] SEEK_CAP_N    = NumW'(1) << 27;
   localparam logic [NumW-1:0] WARM_CAP_N    = NumW'(1) << 28;

   // One divider pipeline stage.
   typedef struct packed {
      logic [NumW-1:0] num;
      logic [DivW-1:0] den;
      logic [7:0]      quo;
      logic            sat;
      logic            zero;
   } dstage_type;

   // Per-item control that travels alongside the dividers.
   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic        startup;
      logic        small_file;
      logic [3:0]  imm;
      logic [6:0]  hot;
      logic [5:0]  warm;
      logic [26:0] rem;
   } side_type;

endpackage

// ----- rtl/rws_cdiv.sv -----
// Pipelined ceiling divider: quo = min(ceil(num / den), 255), zero when den is zero.
// Two quotient bits are resolved per stage over four stages.
module rws_cdiv (
   input  logic                          clock,
   input  logic [rws_pkg::NumW-1:0]      num_in,
   input  logic [rws_pkg::DivW-1:0]      den_in,
   output logic [7:0]                    quo_out
);

   rws_pkg::dstage_type stage_ff [4];
   rws_pkg::dstage_type stage_in [4];
   rws_pkg::dstage_type head;

   // Rounding offset and saturation check ahead of the first stage.
   always_comb begin
      head.num  = num_in + rws_pkg::NumW'(den_in) - rws_pkg::NumW'(den_in != '0);
      head.den  = den_in;
      head.quo  = '0;
      head.zero = (den_in == '0);
      head.sat  = ({{(rws_pkg::CmpW-rws_pkg::NumW){1'b0}}, head.num} >=
                   {den_in, 8'd0});
   end

   // Restoring division, two bits per stage.
   always_comb begin
      rws_pkg::dstage_type cur;
      logic [rws_pkg::CmpW-1:0] shd;
      for (int s = 0; s < 4; s++) begin
         cur = (s == 0) ? head : stage_ff[s-1];
         for (int b = 0; b < 2; b++) begin
            shd = {{8{1'b0}}, cur.den} << (7 - 2*s - b);
            if ({{(rws_pkg::CmpW-rws_pkg::NumW){1'b0}}, cur.num} >= shd) begin
               cur.num = cur.num - shd[rws_pkg::NumW-1:0];
               cur.quo[7-2*s-b] = 1'b1;
            end
         end
         stage_in[s] = cur;
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < 4; s++) begin
         stage_ff[s] <= stage_in[s];
      end
   end

   assign quo_out = stage_ff[3].zero ? 8'd0 :
                    stage_ff[3].sat  ? 8'd255 : stage_ff[3].quo;

endmodule

// ----- rtl/readahead_window_sizer.sv -----
// Read-ahead window sizer. A request is taken whenever start is high; busy is
// always low because the block is a fixed pipeline that accepts one item per
// cycle. Each result appears with rsp_valid seven cycles after its request
// (one classify stage, four stages of the piece-length dividers, one cap stage
// and one clamp stage) and must be taken in that cycle.
module readahead_window_sizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [39:0] req_request_start,
   input  logic [40:0] req_request_length,
   input  logic [40:0] req_file_size,
   input  logic [26:0] req_piece_length,
   input  logic [31:0] req_download_rate,
   input  logic [15:0] req_peer_count,
   input  logic [25:0] req_current_piece,
   input  logic [25:0] req_last_piece,
   input  logic        req_first_byte_sent,
   output logic        rsp_valid,
   output logic [1:0]  rsp_request_kind,
   output logic [3:0]  rsp_immediate_pieces,
   output logic [6:0]  rsp_hot_pieces,
   output logic [7:0]  rsp_warm_pieces
);

   rws_pkg::side_type side_in;
   rws_pkg::side_type side_ff [5];
   logic [rws_pkg::NumW-1:0] na_in, nb_in, nc_in;
   logic [rws_pkg::NumW-1:0] na_ff, nb_ff, nc_ff;
   logic [26:0] pl_ff;
   logic [7:0]  qa, qb, qc, qd;

   assign busy = 1'b0;

   // Classification and divider operands.
   always_comb begin
      logic [47:0] fs95, st100;
      logic        pct_ok, tail_ok, meta;
      logic [40:0] fs_m10;
      logic [6:0]  rh;
      logic [25:0] fsm;
      logic [27:0] target, ceil_b;

      fs95    = 48'(req_file_size) * 48'd95;
      st100   = 48'(req_request_start) * 48'd100 + 48'd99;
      pct_ok  = (fs95 <= st100);
      fs_m10  = req_file_size - rws_pkg::TAIL_MARGIN;
      if (req_file_size < rws_pkg::SMALL_FILE_LIMIT) begin
         tail_ok = pct_ok;
      end else begin
         tail_ok = pct_ok || ({1'b0, req_request_start} >= fs_m10);
      end
      meta = (req_file_size != '0) && (req_request_length != '0) &&
             (req_request_length <= rws_pkg::META_MAX_BYTES) && tail_ok;

      side_in.valid = start;
      if (req_request_start == '0) begin
         side_in.kind = rws_pkg::KIND_INITIAL;
      end else if (meta) begin
         side_in.kind = rws_pkg::KIND_META;
      end else begin
         side_in.kind = rws_pkg::KIND_SEEK;
      end
      side_in.startup = (side_in.kind == rws_pkg::KIND_INITIAL) && !req_first_byte_sent;
      side_in.small_file = (req_file_size != '0) &&
                           (req_file_size <= rws_pkg::SMALL_FILE_LIMIT);

      // Hot window from rate and peers.
      if (req_download_rate > rws_pkg::RATE_FAST) begin
         rh = 7'd96;
      end else if (req_download_rate > rws_pkg::RATE_MID) begin
         rh = 7'd48;
      end else if (req_download_rate > rws_pkg::RATE_SLOW) begin
         rh = 7'd24;
      end else begin
         rh = 7'd16;
      end
      if (req_peer_count < 16'd3 && rh > 7'd24) begin
         rh = 7'd24;
      end

      case (side_in.kind)
         rws_pkg::KIND_INITIAL: begin
            side_in.hot = rh; side_in.imm = 4'd2; side_in.warm = 6'd32;
         end
         rws_pkg::KIND_SEEK: begin
            side_in.hot = (rh < 7'd24) ? 7'd24 : rh;
            side_in.imm = 4'd12; side_in.warm = 6'd32;
         end
         default: begin
            side_in.hot = 7'd2; side_in.imm = 4'd1; side_in.warm = 6'd0;
         end
      endcase
      if (side_in.startup) begin
         side_in.warm = 6'd0;
      end

      // Pieces left from the head, zero when the head is past the end.
      if (req_last_piece >= req_current_piece) begin
         side_in.rem = 27'(req_last_piece) - 27'(req_current_piece) + 27'd1;
      end else begin
         side_in.rem = '0;
      end

      // Startup byte target.
      fsm    = (req_file_size < 41'(rws_pkg::STARTUP_MAX_N)) ?
               req_file_size[25:0] : 26'(rws_pkg::STARTUP_MAX_N);
      target = side_in.small_file ? 28'(fsm) : 28'(rws_pkg::STARTUP_MIN_N);
      ceil_b = (28'(req_piece_length) > 28'(rws_pkg::STARTUP_MAX_N)) ?
               28'(req_piece_length) : 28'(rws_pkg::STARTUP_MAX_N);
      if (target < 28'(req_piece_length)) begin
         target = 28'(req_piece_length);
      end
      if (target > ceil_b) begin
         target = ceil_b;
      end
      na_in = rws_pkg::NumW'(target);
      nb_in = rws_pkg::NumW'(fsm);
      if (side_in.startup) begin
         nc_in = rws_pkg::STARTUP_MAX_N;
      end else if (side_in.kind == rws_pkg::KIND_META) begin
         nc_in = rws_pkg::META_CAP_N;
      end else begin
         nc_in = rws_pkg::SEEK_CAP_N;
      end
   end

   // Classify stage registers.
   always_ff @(posedge clock) begin
      na_ff <= na_in;
      nb_ff <= nb_in;
      nc_ff <= nc_in;
      pl_ff <= req_piece_length;
   end

   // Control line alongside the dividers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) begin
            side_ff[i].valid <= 1'b0;
         end
      end else begin
         side_ff[0] <= side_in;
         for (int i = 1; i < 5; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   rws_cdiv u_div_target (.clock(clock), .num_in(na_ff), .den_in(pl_ff), .quo_out(qa));
   rws_cdiv u_div_small  (.clock(clock), .num_in(nb_ff), .den_in(pl_ff), .quo_out(qb));
   rws_cdiv u_div_hot    (.clock(clock), .num_in(nc_ff), .den_in(pl_ff), .quo_out(qc));
   rws_cdiv u_div_warm   (.clock(clock), .num_in(rws_pkg::WARM_CAP_N), .den_in(pl_ff),
                          .quo_out(qd));

   // Cap stage: startup count and byte caps.
   logic        cap_valid_ff;
   logic [1:0]  cap_kind_ff;
   logic [3:0]  cap_imm_ff;
   logic [7:0]  cap_hot_ff;
   logic [5:0]  cap_warm_ff;
   logic [26:0] cap_rem_ff;
   logic [3:0]  imm_in;
   logic [7:0]  hot_in;
   logic [5:0]  warm_in;

   always_comb begin
      logic [7:0] mxv, mnv, pcs, hot, hcap, wcap;
      rws_pkg::side_type sd;
      sd = side_ff[4];
      if (sd.small_file) begin
         mxv = (qb == 8'd0) ? 8'd1 : ((qb > 8'd32) ? 8'd32 : qb);
      end else begin
         mxv = 8'd4;
      end
      mnv = (mxv >= 8'd2) ? 8'd2 : mxv;
      pcs = (qa < mnv) ? mnv : qa;
      pcs = (pcs > mxv) ? mxv : pcs;
      if (sd.startup) begin
         hot    = pcs;
         imm_in = (pcs > 8'd4) ? 4'd4 : pcs[3:0];
      end else begin
         hot    = 8'(sd.hot);
         imm_in = sd.imm;
      end
      hcap   = (qc == 8'd0) ? 8'd1 : qc;
      hot_in = (hot < hcap) ? hot : hcap;
      wcap   = (qd == 8'd0) ? 8'd1 : qd;
      if (sd.warm == 6'd0) begin
         warm_in = 6'd0;
      end else begin
         warm_in = (8'(sd.warm) < wcap) ? sd.warm : wcap[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_valid_ff <= 1'b0;
      end else begin
         cap_valid_ff <= side_ff[4].valid;
      end
      cap_kind_ff <= side_ff[4].kind;
      cap_imm_ff  <= imm_in;
      cap_hot_ff  <= hot_in;
      cap_warm_ff <= warm_in;
      cap_rem_ff  <= side_ff[4].rem;
   end

   // Clamp stage: limits and pieces remaining.
   logic [6:0] hot_f_in;
   logic [7:0] warm_f_in;
   logic [3:0] imm_f_in;

   always_comb begin
      logic [7:0]  h;
      logic [26:0] rem_hot;
      h = (cap_hot_ff > 8'd96) ? 8'd96 : cap_hot_ff;
      if (cap_rem_ff < 27'(h)) begin
         h = cap_rem_ff[7:0];
      end
      hot_f_in  = h[6:0];
      rem_hot   = cap_rem_ff - 27'(h);
      warm_f_in = 8'(cap_warm_ff);
      if (rem_hot < 27'(warm_f_in)) begin
         warm_f_in = rem_hot[7:0];
      end
      imm_f_in = (8'(cap_imm_ff) < h) ? cap_imm_ff : h[3:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= cap_valid_ff;
      end
      rsp_request_kind     <= cap_kind_ff;
      rsp_immediate_pieces <= imm_f_in;
      rsp_hot_pieces       <= hot_f_in;
      rsp_warm_pieces      <= warm_f_in;
   end

endmodule
